// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define SUA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks during reset.
`define SUA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sua_pkg.sv
`default_nettype none
package sua_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned BYTES   = 8;
  localparam int unsigned LBYTES  = 4;

  localparam logic [DATA_W-1:0] FF0_NONE = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CNT_W-1:0]  CNT_32   = 7'd32;
  localparam logic [CNT_W-1:0]  CNT_64   = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_MOV32    = 4'd0,
    OP_MOV64    = 4'd1,
    OP_CMOV32   = 4'd2,
    OP_CMOV64   = 4'd3,
    OP_NOT32    = 4'd4,
    OP_NOT64    = 4'd5,
    OP_WQM32    = 4'd6,
    OP_WQM64    = 4'd7,
    OP_BREV32   = 4'd8,
    OP_BREV64   = 4'd9,
    OP_BCNT0_32 = 4'd10,
    OP_BCNT0_64 = 4'd11,
    OP_BCNT1_32 = 4'd12,
    OP_BCNT1_64 = 4'd13,
    OP_FF0_32   = 4'd14
  } op_t;

  typedef enum logic [1:0] {
    SEL_BASE,
    SEL_CNT0,
    SEL_CNT1,
    SEL_FF0
  } sel_t;

  typedef struct packed {
    logic            dw;
    logic            two;
    logic            sccw;
    logic            wide;
    sel_t            sel;
  } ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0]        base;
    logic [BYTES-1:0][3:0]    bcnt;
    logic [LBYTES-1:0]        zfound;
    logic [LBYTES-1:0][2:0]   zidx;
    ctrl_t                    ctrl;
  } split_t;

  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [CNT_W-1:0]  total;
    logic              ff0_none;
    logic [4:0]        ff0_idx;
    ctrl_t             ctrl;
  } red_t;

  typedef struct packed {
    logic              scc_write;
    logic              scc_out;
    logic              dest_two_words;
    logic              dest_write;
    logic [DATA_W-1:0] result_value;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/sua_split.sv
`default_nettype none
module sua_split import sua_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [DATA_W-1:0] src,
  input  wire logic              scc,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output split_t                 out_data
);

  split_t nxt;
  logic [DATA_W-1:0] s32;
  logic [DATA_W-1:0] cnt_src;
  logic valid;

  function automatic logic [DATA_W-1:0] nibble_fill(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    for (int q = 0; q < DATA_W / 4; q++) begin
      r[q*4 +: 4] = {4{|x[q*4 +: 4]}};
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rev64(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    for (int i = 0; i < DATA_W; i++) begin
      r[DATA_W-1-i] = x[i];
    end
    return r;
  endfunction

  always_comb begin
    s32 = {32'd0, src[31:0]};
    nxt = '0;
    nxt.ctrl.dw = 1'b1;
    nxt.ctrl.sel = SEL_BASE;
    case (op)
      OP_MOV32: nxt.base = s32;
      OP_MOV64: begin
        nxt.base = src;
        nxt.ctrl.two = 1'b1;
      end
      OP_CMOV32: begin
        nxt.ctrl.dw = scc;
        nxt.base = scc ? s32 : '0;
      end
      OP_CMOV64: begin
        nxt.ctrl.dw = scc;
        nxt.base = scc ? src : '0;
        nxt.ctrl.two = 1'b1;
      end
      OP_NOT32: begin
        nxt.base = {32'd0, ~src[31:0]};
        nxt.ctrl.sccw = 1'b1;
      end
      OP_NOT64: begin
        nxt.base = ~src;
        nxt.ctrl.two = 1'b1;
        nxt.ctrl.sccw = 1'b1;
      end
      OP_WQM32: begin
        nxt.base = nibble_fill(s32);
        nxt.ctrl.sccw = 1'b1;
      end
      OP_WQM64: begin
        nxt.base = nibble_fill(src);
        nxt.ctrl.two = 1'b1;
        nxt.ctrl.sccw = 1'b1;
      end
      OP_BREV32: nxt.base = rev64(s32) >> 32;
      OP_BREV64: begin
        nxt.base = rev64(src);
        nxt.ctrl.two = 1'b1;
      end
      OP_BCNT0_32: begin
        nxt.ctrl.sel = SEL_CNT0;
        nxt.ctrl.sccw = 1'b1;
      end
      OP_BCNT0_64: begin
        nxt.ctrl.sel = SEL_CNT0;
        nxt.ctrl.sccw = 1'b1;
        nxt.ctrl.wide = 1'b1;
      end
      OP_BCNT1_32: begin
        nxt.ctrl.sel = SEL_CNT1;
        nxt.ctrl.sccw = 1'b1;
      end
      OP_BCNT1_64: begin
        nxt.ctrl.sel = SEL_CNT1;
        nxt.ctrl.sccw = 1'b1;
        nxt.ctrl.wide = 1'b1;
      end
      OP_FF0_32: nxt.ctrl.sel = SEL_FF0;
      default: nxt.ctrl.dw = 1'b0;
    endcase

    // byte-wise ones count, high word masked for the narrow forms
    cnt_src = nxt.ctrl.wide ? src : s32;
    for (int b = 0; b < BYTES; b++) begin
      nxt.bcnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        nxt.bcnt[b] = nxt.bcnt[b] + {3'd0, cnt_src[b*8 + i]};
      end
    end

    // lowest zero bit inside each byte of the low word
    for (int b = 0; b < LBYTES; b++) begin
      nxt.zfound[b] = ~&src[b*8 +: 8];
      nxt.zidx[b] = '0;
      for (int i = 7; i >= 0; i--) begin
        if (!src[b*8 + i]) nxt.zidx[b] = 3'(i);
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sua_reduce.sv
`default_nettype none
module sua_reduce import sua_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  split_t      in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output red_t        out_data
);

  red_t nxt;
  logic valid;

  always_comb begin
    nxt.base = in_data.base;
    nxt.ctrl = in_data.ctrl;
    nxt.total = '0;
    for (int b = 0; b < BYTES; b++) begin
      nxt.total = nxt.total + CNT_W'(in_data.bcnt[b]);
    end
    // lowest byte with a zero wins
    nxt.ff0_none = ~|in_data.zfound;
    nxt.ff0_idx = '0;
    for (int b = LBYTES - 1; b >= 0; b--) begin
      if (in_data.zfound[b]) nxt.ff0_idx = {2'(b), in_data.zidx[b]};
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sua_finish.sv
`default_nettype none
module sua_finish import sua_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  red_t        in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output res_t        out_data
);

  res_t nxt;
  logic [CNT_W-1:0] width_bits;
  logic valid;

  always_comb begin
    width_bits = in_data.ctrl.wide ? CNT_64 : CNT_32;
    case (in_data.ctrl.sel)
      SEL_BASE: nxt.result_value = in_data.base;
      SEL_CNT0: nxt.result_value = {57'd0, width_bits - in_data.total};
      SEL_CNT1: nxt.result_value = {57'd0, in_data.total};
      SEL_FF0:  nxt.result_value = in_data.ff0_none ? FF0_NONE : {59'd0, in_data.ff0_idx};
      default:  nxt.result_value = in_data.base;
    endcase
    nxt.dest_write     = in_data.ctrl.dw;
    nxt.dest_two_words = in_data.ctrl.two;
    nxt.scc_write      = in_data.ctrl.sccw;
    nxt.scc_out        = in_data.ctrl.sccw && (|nxt.result_value);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/scalar_unary_alu.sv
// Scalar single-source ALU. Takes one instruction beat per cycle while the
// output is not stalled and returns one result beat for each, in order,
// through three register stages: opcode decode with per-byte ones counts and
// zero search, reduction of the byte partials, then final select with the
// condition code. Every stage holds its beat under backpressure, so bubbles
// close up and nothing is dropped.
`default_nettype none
module scalar_unary_alu import sua_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // [63:0] src, [64] scc_in, [71:65] zero
  input  wire logic [3:0]  s_tuser,  // [3:0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata   // [63:0] result_value, [64] dest_write,
                                     // [65] dest_two_words, [66] scc_out,
                                     // [67] scc_write, [71:68] zero
);

  split_t split_data;
  red_t   red_data;
  res_t   res_data;
  logic   split_valid, split_ready;
  logic   red_valid, red_ready;

  sua_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (s_tuser),
    .src       (s_tdata[63:0]),
    .scc       (s_tdata[64]),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  sua_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_data  (red_data)
  );

  sua_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_data   (red_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_data)
  );

  assign m_tdata = {4'd0, res_data};

endmodule
`default_nettype wire

// File: rtl/core/sua_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sua_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);

  `SUA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
  `SUA_ASSERT(a_scc_needs_write, m_tvalid |-> !(m_tdata[66] && !m_tdata[67]), "scc_out set without scc_write")
  `SUA_ASSERT(a_narrow_upper_zero, m_tvalid && !m_tdata[65] |-> m_tdata[63:32] == 32'd0, "single-word result has upper bits set")
  `SUA_ASSERT(a_latency, (s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready) |=> m_tvalid, "accepted beat did not reach output in three cycles")
  `SUA_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule

bind scalar_unary_alu sua_checker u_sua_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sua_pkg::*;

  // Expected results of the scalar ALU, kept in issue order.
  class result_book;
    res_t pending[$];
    int unsigned mismatches;

    function res_t compute(op_t op, logic [63:0] src, logic scc);
      res_t r;
      logic [63:0] v;
      logic sccw;
      int i;
      r = '0;
      r.dest_write = 1'b1;
      v = '0;
      sccw = 1'b0;
      case (op)
        OP_MOV32: v = {32'h0, src[31:0]};
        OP_MOV64: begin
          v = src;
          r.dest_two_words = 1'b1;
        end
        OP_CMOV32: begin
          r.dest_write = scc;
          v = scc ? {32'h0, src[31:0]} : 64'h0;
        end
        OP_CMOV64: begin
          r.dest_write = scc;
          v = scc ? src : 64'h0;
          r.dest_two_words = 1'b1;
        end
        OP_NOT32: begin
          v = {32'h0, ~src[31:0]};
          sccw = 1'b1;
        end
        OP_NOT64: begin
          v = ~src;
          r.dest_two_words = 1'b1;
          sccw = 1'b1;
        end
        OP_WQM32: begin
          for (i = 0; i < 8; i++)
            if (src[4*i +: 4] != 4'h0) v[4*i +: 4] = 4'hF;
          sccw = 1'b1;
        end
        OP_WQM64: begin
          for (i = 0; i < 16; i++)
            if (src[4*i +: 4] != 4'h0) v[4*i +: 4] = 4'hF;
          r.dest_two_words = 1'b1;
          sccw = 1'b1;
        end
        OP_BREV32: begin
          for (i = 0; i < 32; i++) v[31-i] = src[i];
        end
        OP_BREV64: begin
          for (i = 0; i < 64; i++) v[63-i] = src[i];
          r.dest_two_words = 1'b1;
        end
        OP_BCNT0_32: begin
          v = 64'(32 - $countones(src[31:0]));
          sccw = 1'b1;
        end
        OP_BCNT0_64: begin
          v = 64'(64 - $countones(src));
          sccw = 1'b1;
        end
        OP_BCNT1_32: begin
          v = 64'($countones(src[31:0]));
          sccw = 1'b1;
        end
        OP_BCNT1_64: begin
          v = 64'($countones(src));
          sccw = 1'b1;
        end
        OP_FF0_32: begin
          // scan downward so the lowest zero wins
          v = FF0_NONE;
          for (i = 31; i >= 0; i--)
            if (!src[i]) v = 64'(i);
        end
        default: r.dest_write = 1'b0;
      endcase
      r.result_value = v;
      r.scc_write = sccw;
      r.scc_out = sccw && (v != 64'h0);
      return r;
    endfunction

    function void note_instr(op_t op, logic [63:0] src, logic scc);
      pending.push_back(compute(op, src, scc));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing outstanding: %h", got);
        return;
      end
      want = pending.pop_front();
      compare_field("result_value", want.result_value, got.result_value);
      compare_field("dest_write", 64'(want.dest_write), 64'(got.dest_write));
      compare_field("dest_two_words", 64'(want.dest_two_words), 64'(got.dest_two_words));
      compare_field("scc_out", 64'(want.scc_out), 64'(got.scc_out));
      compare_field("scc_write", 64'(want.scc_write), 64'(got.scc_write));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // [63:0] src, [64] scc_in, [71:65] zero
  logic [3:0]  s_tuser;   // [3:0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [63:0] result_value, [64] dest_write, [65] dest_two_words,
                          // [66] scc_out, [67] scc_write, [71:68] zero

  int send_idle;
  int recv_idle;
  int hold_len;
  result_book book;

  scalar_unary_alu dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Receiver: a pending hold-off wins over random stalls.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      m_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        book.note_instr(op_t'(s_tuser), s_tdata[63:0], s_tdata[64]);
      if (m_tvalid && m_tready)
        book.check_result(res_t'(m_tdata[67:0]));
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(op_t op, logic [63:0] src, logic scc);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, scc, src};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_item();
    op_t op;
    logic [63:0] src;
    int k;
    op = op_t'($urandom_range(14));
    k = $urandom_range(63);
    case ($urandom_range(7))
      0, 1, 2: src = {$urandom, $urandom};
      3: src = ~(64'h1 << k);
      4: begin
        // ones below a chosen bit, zero at it; bit 32 leaves no zero in the low word
        k = $urandom_range(32);
        src = {$urandom, $urandom} | ((64'h1 << k) - 64'h1);
        src[k] = 1'b0;
      end
      5: src = 64'h1 << k;
      6: src = $urandom_range(1) ? '1 : '0;
      default: src = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    send_item(op, src, 1'(($urandom_range(1))));
  endtask

  task automatic drain();
    while (book.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic run_phase(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) send_random_item();
    s_tvalid <= 1'b0;
    drain();
  endtask

  task automatic send_directed();
    send_item(OP_MOV32,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(OP_MOV64,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // conditional moves with the condition clear and set
    send_item(OP_CMOV32,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(OP_CMOV32,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_item(OP_CMOV64,   64'h8000_0000_0000_0001, 1'b0);
    send_item(OP_CMOV64,   64'h8000_0000_0000_0001, 1'b1);
    send_item(OP_NOT32,    64'h1234_5678_FFFF_FFFF, 1'b1);
    send_item(OP_NOT64,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_item(OP_NOT64,    64'h0000_0000_0000_0000, 1'b1);
    send_item(OP_WQM32,    64'hFFFF_FFFF_0000_0000, 1'b0);
    send_item(OP_WQM32,    64'hFFFF_FFFF_1000_0201, 1'b0);
    send_item(OP_WQM64,    64'h8000_0000_0000_0001, 1'b1);
    send_item(OP_BREV32,   64'hFFFF_FFFF_0000_0001, 1'b0);
    send_item(OP_BREV64,   64'h0000_0000_0000_0001, 1'b0);
    send_item(OP_BCNT0_32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_item(OP_BCNT0_64, 64'h0000_0000_0000_0000, 1'b0);
    send_item(OP_BCNT1_32, 64'hFFFF_FFFF_0000_0000, 1'b1);
    send_item(OP_BCNT1_64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    // find-first-zero: none in the low word, top bit only, bit zero
    send_item(OP_FF0_32,   64'h0000_0000_FFFF_FFFF, 1'b1);
    send_item(OP_FF0_32,   64'h0000_0000_7FFF_FFFF, 1'b0);
    send_item(OP_FF0_32,   64'h0000_0000_0000_0000, 1'b0);
    send_item(OP_FF0_32,   64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    s_tvalid <= 1'b0;
    drain();
  endtask

  initial begin
    book = new;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    hold_len = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 36;
    recv_idle = 55;
    send_directed();

    run_phase(260, 36, 55);
    run_phase(260, 55, 36);

    // Stall the output long enough that the pipe backs up into the input.
    send_idle = 0;
    recv_idle = 0;
    hold_len = 80;
    repeat (40) send_random_item();
    s_tvalid <= 1'b0;
    drain();

    run_phase(280, 0, 0);

    repeat (10) @(posedge clk);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
